// ===== hdl/dmanq_pkg.sv =====
// Shared types and constants for the dual moving average note quantizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package dmanq_pkg;

	localparam int SAMPLE_W = 10;
	localparam int AVG_W    = 10;
	localparam int NOTE_W   = 7;
	localparam int TRANS_W  = 7;
	localparam int MAX_SAMPLE = (2 ** SAMPLE_W) - 1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
	} sample_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [AVG_W-1:0]  average_b;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]           range_start;
		logic [SAMPLE_W-1:0]           range_end;
		logic signed [TRANS_W-1:0]     transpose;
		logic [3:0][NOTE_W-1:0]        notes;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_RANGE_START = 3'd0,
		REG_RANGE_END   = 3'd1,
		REG_TRANSPOSE   = 3'd2,
		REG_NOTE_FIRST  = 3'd3,
		REG_NOTE_SECOND = 3'd4,
		REG_NOTE_THIRD  = 3'd5,
		REG_NOTE_FOURTH = 3'd6
	} reg_addr_t;

	localparam logic [SAMPLE_W-1:0] RST_RANGE_START = 10'd120;
	localparam logic [SAMPLE_W-1:0] RST_RANGE_END   = 10'd590;
	localparam logic [TRANS_W-1:0]  RST_TRANSPOSE   = 7'd0;
	localparam logic [NOTE_W-1:0]   RST_NOTE_FIRST  = 7'd71;
	localparam logic [NOTE_W-1:0]   RST_NOTE_SECOND = 7'd68;
	localparam logic [NOTE_W-1:0]   RST_NOTE_THIRD  = 7'd62;
	localparam logic [NOTE_W-1:0]   RST_NOTE_FOURTH = 7'd59;

endpackage

`default_nettype wire

// ===== hdl/dmanq_lane.sv =====
// One averaging lane: sample ring memory, running total and division by the window.
// Depends on dmanq_pkg for sample and average widths.
`default_nettype none

module dmanq_lane #(
	parameter int WINDOW = 100,
	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [dmanq_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [POS_W-1:0]                pos,
	input  wire logic                            wrapped,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [dmanq_pkg::AVG_W-1:0]          average
);

	localparam int SUM_W = $clog2(WINDOW * dmanq_pkg::MAX_SAMPLE + 1);
	localparam int SHIFT = SUM_W;
	localparam longint RECIP = (longint'(1) << SHIFT) / WINDOW;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [SUM_W-1:0]   WIN_C   = SUM_W'(WINDOW);

	logic [dmanq_pkg::SAMPLE_W-1:0] mem [WINDOW];

	logic                           vld_s1, vld_s2, vld_s3, vld_s4;
	logic                           en1, en2, en3, en4;
	logic [dmanq_pkg::SAMPLE_W-1:0] samp_s1, rd_s1, old_sample;
	logic [POS_W-1:0]               pos_s1;
	logic                           wrap_s1;
	logic [SUM_W-1:0]               sum_q, sum_next, sum_s3, rem;
	logic [PROD_W-1:0]              prod_s3;
	logic [dmanq_pkg::AVG_W-1:0]    q_est, avg_s4;

	assign en4 = !vld_s4 || out_ready;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	// Until the ring has wrapped once, the slot being replaced is treated as zero, as the memory has no reset.
	assign old_sample = wrap_s1 ? rd_s1 : '0;
	assign sum_next = sum_q - SUM_W'(old_sample) + SUM_W'(samp_s1);

	// The reciprocal estimate is low by at most one; one compare fixes it.
	assign q_est = prod_s3[SHIFT +: dmanq_pkg::AVG_W];
	assign rem = sum_s3 - SUM_W'(q_est) * WIN_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			sum_q  <= '0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en2 && vld_s1) sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			samp_s1 <= sample;
			pos_s1  <= pos;
			wrap_s1 <= wrapped;
			rd_s1   <= mem[pos];
		end
		if (en2 && vld_s1) begin
			mem[pos_s1] <= samp_s1;
		end
		if (en3 && vld_s2) begin
			prod_s3 <= PROD_W'(sum_q) * PROD_W'(RECIP_C);
			sum_s3  <= sum_q;
		end
		if (en4 && vld_s3) begin
			avg_s4 <= q_est + dmanq_pkg::AVG_W'(rem >= WIN_C);
		end
	end

	assign out_valid = vld_s4;
	assign average = avg_s4;

endmodule

`default_nettype wire

// ===== hdl/dmanq_merge.sv =====
// Merging stage: quantizes lane A's average to a note and pairs it with lane B's average.
// Depends on dmanq_pkg for the configuration and result types.
`default_nettype none

module dmanq_merge (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [dmanq_pkg::AVG_W-1:0]  average_a,
	input  wire logic [dmanq_pkg::AVG_W-1:0]  average_b,
	input  wire dmanq_pkg::cfg_t              cfg,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output dmanq_pkg::result_t                result
);

	logic signed [dmanq_pkg::AVG_W:0] span;
	logic                             span_ok, above, above_end, in_range;
	logic [dmanq_pkg::AVG_W-3:0]      seg;
	logic [dmanq_pkg::AVG_W-1:0]      b1, b2, b3, b4, d, dist_s, dist_e;
	logic [1:0]                       sel;

	logic                             vld_s5, vld_q, en5, eno;
	logic [1:0]                       sel_s5;
	logic [dmanq_pkg::AVG_W-1:0]      avgb_s5;
	logic signed [dmanq_pkg::NOTE_W+1:0] note_sum;
	logic [dmanq_pkg::NOTE_W-1:0]     note_sat;
	dmanq_pkg::result_t               result_q;

	// Segments exist only when the range spans at least four values.
	always_comb begin
		span = $signed({1'b0, cfg.range_end}) - $signed({1'b0, cfg.range_start});
		span_ok = !span[dmanq_pkg::AVG_W] && (span[dmanq_pkg::AVG_W-1:2] != '0);
		seg = span[dmanq_pkg::AVG_W-1:2];
		b1 = {2'b00, seg};
		b2 = {1'b0, seg, 1'b0};
		b3 = b1 + b2;
		b4 = {seg, 2'b00};
		above = average_a >= cfg.range_start;
		above_end = average_a >= cfg.range_end;
		d = average_a - cfg.range_start;
		dist_s = above ? d : (cfg.range_start - average_a);
		dist_e = above_end ? (average_a - cfg.range_end) : (cfg.range_end - average_a);
		in_range = span_ok && above && (d < b4);
		if (in_range) begin
			if (d < b1) sel = 2'd0;
			else if (d < b2) sel = 2'd1;
			else if (d < b3) sel = 2'd2;
			else sel = 2'd3;
		end else begin
			sel = (dist_s < dist_e) ? 2'd0 : 2'd3;
		end
	end

	always_comb begin
		note_sum = $signed({2'b00, cfg.notes[sel_s5]})
			+ $signed({{2{cfg.transpose[dmanq_pkg::TRANS_W-1]}}, cfg.transpose});
		if (note_sum < 0) begin
			note_sat = '0;
		end else if (note_sum > $signed(9'd127)) begin
			note_sat = '1;
		end else begin
			note_sat = note_sum[dmanq_pkg::NOTE_W-1:0];
		end
	end

	assign eno = !vld_q || out_ready;
	assign en5 = !vld_s5 || eno;
	assign in_ready = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (en5) vld_s5 <= in_valid;
			if (eno) vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && in_valid) begin
			sel_s5  <= sel;
			avgb_s5 <= average_b;
		end
		if (eno && vld_s5) begin
			result_q.note      <= note_sat;
			result_q.average_b <= avgb_s5;
		end
	end

	assign out_valid = vld_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hdl/dual_moving_average_note_quantizer_core.sv =====
// Top level: configuration registers, shared ring position, two averaging lanes and the merge.
// Depends on dmanq_pkg, dmanq_lane and dmanq_merge.
// Pipeline: 4 lane stages, 2 merge stages; one sample pair per cycle unless result_ready stalls.
// Each lane's ring memory is read and written once per cycle.
// Reset clears the running totals, the ring position and the pipeline valid bits at once.
// Ring slots read as zero until the position first wraps, so no clearing pass is needed.
`default_nettype none

module dual_moving_average_note_quantizer_core #(
	parameter int WINDOW = 100,
	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire dmanq_pkg::sample_t    sample,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output dmanq_pkg::result_t         result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [4:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	dmanq_pkg::cfg_t      cfg_q;
	dmanq_pkg::reg_addr_t reg_addr;
	logic                 cfg_wr;
	logic [POS_W-1:0]     pos_q;
	logic                 wrapped_q, accept, pos_last;
	logic                 a_ready, b_ready, a_valid, b_valid, merge_ready;
	logic [dmanq_pkg::AVG_W-1:0] avg_a, avg_b;

	assign pready = 1'b1;
	assign reg_addr = dmanq_pkg::reg_addr_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_start <= dmanq_pkg::RST_RANGE_START;
			cfg_q.range_end   <= dmanq_pkg::RST_RANGE_END;
			cfg_q.transpose   <= dmanq_pkg::RST_TRANSPOSE;
			cfg_q.notes[0]    <= dmanq_pkg::RST_NOTE_FIRST;
			cfg_q.notes[1]    <= dmanq_pkg::RST_NOTE_SECOND;
			cfg_q.notes[2]    <= dmanq_pkg::RST_NOTE_THIRD;
			cfg_q.notes[3]    <= dmanq_pkg::RST_NOTE_FOURTH;
		end else if (cfg_wr) begin
			unique case (reg_addr)
				dmanq_pkg::REG_RANGE_START: cfg_q.range_start <= pwdata[9:0];
				dmanq_pkg::REG_RANGE_END:   cfg_q.range_end   <= pwdata[9:0];
				dmanq_pkg::REG_TRANSPOSE:   cfg_q.transpose   <= pwdata[6:0];
				dmanq_pkg::REG_NOTE_FIRST:  cfg_q.notes[0]    <= pwdata[6:0];
				dmanq_pkg::REG_NOTE_SECOND: cfg_q.notes[1]    <= pwdata[6:0];
				dmanq_pkg::REG_NOTE_THIRD:  cfg_q.notes[2]    <= pwdata[6:0];
				dmanq_pkg::REG_NOTE_FOURTH: cfg_q.notes[3]    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_addr)
			dmanq_pkg::REG_RANGE_START: prdata = 32'(cfg_q.range_start);
			dmanq_pkg::REG_RANGE_END:   prdata = 32'(cfg_q.range_end);
			dmanq_pkg::REG_TRANSPOSE:   prdata = {25'd0, cfg_q.transpose};
			dmanq_pkg::REG_NOTE_FIRST:  prdata = 32'(cfg_q.notes[0]);
			dmanq_pkg::REG_NOTE_SECOND: prdata = 32'(cfg_q.notes[1]);
			dmanq_pkg::REG_NOTE_THIRD:  prdata = 32'(cfg_q.notes[2]);
			dmanq_pkg::REG_NOTE_FOURTH: prdata = 32'(cfg_q.notes[3]);
			default: prdata = '0;
		endcase
	end

	// Both lanes share one ring position; it advances on every sample transfer.
	assign sample_ready = a_ready && b_ready;
	assign accept = sample_valid && sample_ready;
	assign pos_last = (pos_q == POS_W'(WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (pos_last) begin
				pos_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	dmanq_lane #(.WINDOW(WINDOW)) u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (a_ready),
		.sample    (sample.sample_a),
		.pos       (pos_q),
		.wrapped   (wrapped_q),
		.out_valid (a_valid),
		.out_ready (merge_ready),
		.average   (avg_a)
	);

	dmanq_lane #(.WINDOW(WINDOW)) u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (b_ready),
		.sample    (sample.sample_b),
		.pos       (pos_q),
		.wrapped   (wrapped_q),
		.out_valid (b_valid),
		.out_ready (merge_ready),
		.average   (avg_b)
	);

	dmanq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid && b_valid),
		.in_ready  (merge_ready),
		.average_a (avg_a),
		.average_b (avg_b),
		.cfg       (cfg_q),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.result    (result)
	);

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid == b_valid) && (a_ready == b_ready))
		else $error("averaging lanes fell out of step");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < (POS_W + 1)'(WINDOW))
		else $error("ring position beyond the window");

	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_last) |=> (wrapped_q && (pos_q == '0)))
		else $error("ring position did not wrap after the last slot");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("wrap flag cleared outside reset");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for dual_moving_average_note_quantizer_core: directed and random sample pairs,
// with every result checked against a predictor of both moving averages and the note quantizer.
// Depends on dmanq_pkg and the core RTL.

module tb_top;

	localparam int WIN = 100;
	localparam int LATENCY = 6;
	localparam int BAD_REG_INDEX = 7;
	localparam int MAX_REPORTS = 40;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	dmanq_pkg::sample_t    pair_in = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	dmanq_pkg::result_t    pair_out;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [4:0]            paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	dual_moving_average_note_quantizer_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (pair_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (pair_out),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #6 clk = ~clk;

	// Predictor state: both rings, running totals, shared position and the registers.
	logic [dmanq_pkg::SAMPLE_W-1:0]       ring_a [WIN];
	logic [dmanq_pkg::SAMPLE_W-1:0]       ring_b [WIN];
	logic [16:0]                          tot_a = '0;
	logic [16:0]                          tot_b = '0;
	int                                   ring_pos = 0;
	logic [dmanq_pkg::SAMPLE_W-1:0]       cfg_start = dmanq_pkg::RST_RANGE_START;
	logic [dmanq_pkg::SAMPLE_W-1:0]       cfg_end = dmanq_pkg::RST_RANGE_END;
	logic signed [dmanq_pkg::TRANS_W-1:0] cfg_transpose = dmanq_pkg::RST_TRANSPOSE;
	logic [dmanq_pkg::NOTE_W-1:0]         cfg_notes [4];

	dmanq_pkg::result_t note_avg_queue [$];
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      hold_req = 0;
	int      hold_ack = 0;
	int      hold_left = 0;

	// Random stimulus holds each sensor near a level for a run, so the averages settle.
	int level_a = 0;
	int level_b = 0;
	int noise_amp = 0;
	int run_left = 0;

	function automatic logic [dmanq_pkg::NOTE_W-1:0] quantize_note(input int avg);
		int rs, re, seg, sel, n, dist_start, dist_end;
		rs = int'(cfg_start);
		re = int'(cfg_end);
		seg = (re - rs) / 4;
		sel = -1;
		for (int i = 0; i < 4; i++) begin
			if (sel < 0 && avg >= rs + seg * i && avg <= rs + seg * (i + 1) - 1)
				sel = i;
		end
		if (sel < 0) begin
			dist_start = (avg < rs) ? rs - avg : avg - rs;
			dist_end = (avg < re) ? re - avg : avg - re;
			sel = (dist_start < dist_end) ? 0 : 3;
		end
		n = int'(cfg_notes[sel]) + int'(cfg_transpose);
		if (n < 0)
			n = 0;
		if (n > 127)
			n = 127;
		return dmanq_pkg::NOTE_W'(n);
	endfunction

	task automatic advance_averages(input dmanq_pkg::sample_t s);
		dmanq_pkg::result_t r;
		tot_a = tot_a - ring_a[ring_pos] + s.sample_a;
		ring_a[ring_pos] = s.sample_a;
		tot_b = tot_b - ring_b[ring_pos] + s.sample_b;
		ring_b[ring_pos] = s.sample_b;
		r.note = quantize_note(int'(tot_a / WIN));
		r.average_b = dmanq_pkg::AVG_W'(tot_b / WIN);
		note_avg_queue.push_back(r);
		ring_pos = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Sender: optional idle cycles, then hold the pair until the transfer happens.
	task automatic offer_pair(input dmanq_pkg::sample_t s);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		pair_in <= s;
		forever begin
			@(posedge clk);
			if (sample_ready)
				break;
		end
		advance_averages(s);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (note_avg_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input int unsigned idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			dmanq_pkg::REG_RANGE_START: cfg_start = value[dmanq_pkg::SAMPLE_W-1:0];
			dmanq_pkg::REG_RANGE_END:   cfg_end = value[dmanq_pkg::SAMPLE_W-1:0];
			dmanq_pkg::REG_TRANSPOSE:   cfg_transpose = value[dmanq_pkg::TRANS_W-1:0];
			dmanq_pkg::REG_NOTE_FIRST:  cfg_notes[0] = value[dmanq_pkg::NOTE_W-1:0];
			dmanq_pkg::REG_NOTE_SECOND: cfg_notes[1] = value[dmanq_pkg::NOTE_W-1:0];
			dmanq_pkg::REG_NOTE_THIRD:  cfg_notes[2] = value[dmanq_pkg::NOTE_W-1:0];
			dmanq_pkg::REG_NOTE_FOURTH: cfg_notes[3] = value[dmanq_pkg::NOTE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_config(input int rs, input int re, input int tr,
			input int n0, input int n1, input int n2, input int n3);
		write_reg(dmanq_pkg::REG_RANGE_START, 32'(rs));
		write_reg(dmanq_pkg::REG_RANGE_END, 32'(re));
		write_reg(dmanq_pkg::REG_TRANSPOSE, 32'(tr));
		write_reg(dmanq_pkg::REG_NOTE_FIRST, 32'(n0));
		write_reg(dmanq_pkg::REG_NOTE_SECOND, 32'(n1));
		write_reg(dmanq_pkg::REG_NOTE_THIRD, 32'(n2));
		write_reg(dmanq_pkg::REG_NOTE_FOURTH, 32'(n3));
	endtask

	function automatic int pick_level();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return dmanq_pkg::MAX_SAMPLE;
			default: return int'($urandom_range(0, dmanq_pkg::MAX_SAMPLE));
		endcase
	endfunction

	function automatic int pick_note();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 127;
			default: return int'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic dmanq_pkg::sample_t next_level_pair();
		dmanq_pkg::sample_t s;
		int na, nb;
		if (run_left == 0) begin
			level_a = pick_level();
			level_b = pick_level();
			noise_amp = int'($urandom_range(0, 64));
			run_left = int'($urandom_range(30, 150));
		end
		run_left--;
		// A share of pure noise breaks up the steady runs.
		if ($urandom_range(0, 9) == 0) begin
			s.sample_a = dmanq_pkg::SAMPLE_W'($urandom);
			s.sample_b = dmanq_pkg::SAMPLE_W'($urandom);
			return s;
		end
		na = level_a + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
		nb = level_b + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
		na = (na < 0) ? 0 : (na > dmanq_pkg::MAX_SAMPLE) ? dmanq_pkg::MAX_SAMPLE : na;
		nb = (nb < 0) ? 0 : (nb > dmanq_pkg::MAX_SAMPLE) ? dmanq_pkg::MAX_SAMPLE : nb;
		s.sample_a = dmanq_pkg::SAMPLE_W'(na);
		s.sample_b = dmanq_pkg::SAMPLE_W'(nb);
		return s;
	endfunction

	task automatic random_config();
		int rs, re, mid, d, tr;
		mid = int'(tot_a / WIN);
		case ($urandom_range(0, 9))
			0, 1: begin
				rs = 0;
				re = dmanq_pkg::MAX_SAMPLE;
			end
			2, 3: begin
				// Inverted range centered on the current average, so ties can occur.
				d = int'($urandom_range(0, 40));
				rs = (mid + d > dmanq_pkg::MAX_SAMPLE) ? dmanq_pkg::MAX_SAMPLE : mid + d;
				re = (mid - d < 0) ? 0 : mid - d;
			end
			4: begin
				rs = int'($urandom_range(0, dmanq_pkg::MAX_SAMPLE - 3));
				re = rs + int'($urandom_range(0, 3));
			end
			5: begin
				rs = int'($urandom_range(0, dmanq_pkg::MAX_SAMPLE));
				re = int'($urandom_range(0, dmanq_pkg::MAX_SAMPLE));
			end
			default: begin
				rs = int'($urandom_range(0, 900));
				re = int'($urandom_range(rs + 4, dmanq_pkg::MAX_SAMPLE));
			end
		endcase
		case ($urandom_range(0, 7))
			0: tr = -48;
			1: tr = 48;
			default: tr = int'($urandom_range(0, 96)) - 48;
		endcase
		write_config(rs, re, tr, pick_note(), pick_note(), pick_note(), pick_note());
	endtask

	task automatic test_reset_values();
		offer_pair('{sample_a: 10'd0, sample_b: 10'd0});
		offer_pair('{sample_a: 10'h3FF, sample_b: 10'h3FF});
		offer_pair('{sample_a: 10'h155, sample_b: 10'h2AA});
		offer_pair('{sample_a: 10'h2AA, sample_b: 10'h155});
	endtask

	// Full-scale samples raise the average by about ten per transfer, walking it
	// through all four segments of width ten and then past the top of the range.
	task automatic test_segments();
		int rs;
		wait_drained();
		rs = int'(tot_a / WIN) + 5;
		write_config(rs, rs + 40, 0, 10, 20, 30, 40);
		repeat (5) offer_pair('{sample_a: 10'h3FF, sample_b: 10'd0});
	endtask

	// Zero samples leave the first average unchanged while the ring still holds zeros.
	task automatic test_narrow_and_inverted();
		int avg;
		wait_drained();
		avg = int'(tot_a / WIN);
		write_config(avg + 20, (avg < 20) ? 0 : avg - 20, 0, 1, 2, 3, 4);
		repeat (2) offer_pair('{sample_a: 10'd0, sample_b: dmanq_pkg::SAMPLE_W'($urandom)});
		wait_drained();
		write_reg(dmanq_pkg::REG_RANGE_START, 32'(avg));
		write_reg(dmanq_pkg::REG_RANGE_END, 32'(avg));
		repeat (2) offer_pair('{sample_a: 10'd0, sample_b: dmanq_pkg::SAMPLE_W'($urandom)});
		wait_drained();
		write_reg(dmanq_pkg::REG_RANGE_START, 32'(avg - 1));
		write_reg(dmanq_pkg::REG_RANGE_END, 32'(avg + 2));
		repeat (2) offer_pair('{sample_a: 10'd0, sample_b: dmanq_pkg::SAMPLE_W'($urandom)});
	endtask

	task automatic test_transpose_saturation();
		wait_drained();
		write_config(0, dmanq_pkg::MAX_SAMPLE, 48, 127, 127, 127, 127);
		repeat (2) offer_pair('{sample_a: dmanq_pkg::SAMPLE_W'($urandom), sample_b: 10'h3FF});
		wait_drained();
		write_config(0, dmanq_pkg::MAX_SAMPLE, -48, 0, 0, 0, 0);
		repeat (2) offer_pair('{sample_a: dmanq_pkg::SAMPLE_W'($urandom), sample_b: 10'd0});
	endtask

	task automatic test_unknown_register();
		wait_drained();
		write_reg(BAD_REG_INDEX, 32'h7F);
		repeat (2) offer_pair('{sample_a: dmanq_pkg::SAMPLE_W'($urandom),
			sample_b: dmanq_pkg::SAMPLE_W'($urandom)});
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure();
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = hold_req + 1;
		repeat (60) offer_pair(next_level_pair());
	endtask

	task automatic test_random_levels(input int chunks, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (chunks) begin
			wait_drained();
			random_config();
			repeat ($urandom_range(80, 110)) offer_pair(next_level_pair());
		end
	endtask

	// A new hold request starts a stretch of cycles in which the receiver refuses results.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		dmanq_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (note_avg_queue.size() == 0) begin
				report_mismatch("result transfer with none expected", pair_out.note, -1);
			end else begin
				want = note_avg_queue.pop_front();
				if (pair_out.note !== want.note)
					report_mismatch("note", pair_out.note, want.note);
				if (pair_out.average_b !== want.average_b)
					report_mismatch("average_b", pair_out.average_b, want.average_b);
			end
		end
	end

	initial begin
		for (int i = 0; i < WIN; i++) begin
			ring_a[i] = '0;
			ring_b[i] = '0;
		end
		cfg_notes[0] = dmanq_pkg::RST_NOTE_FIRST;
		cfg_notes[1] = dmanq_pkg::RST_NOTE_SECOND;
		cfg_notes[2] = dmanq_pkg::RST_NOTE_THIRD;
		cfg_notes[3] = dmanq_pkg::RST_NOTE_FOURTH;
		send_idle_pct = 10;
		recv_idle_pct = 66;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_segments();
		test_narrow_and_inverted();
		test_transpose_saturation();
		test_unknown_register();
		test_random_levels(6, 10, 66);
		test_backpressure();
		test_random_levels(6, 66, 10);
		test_random_levels(6, 0, 0);
		wait_drained();

		if (mismatch_count == 0)
			$display("dual_moving_average_note_quantizer_core: match");
		else
			$display("dual_moving_average_note_quantizer_core: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("dual_moving_average_note_quantizer_core: mismatch");
		$finish;
	end

endmodule
